// ----- rtl/core/aerd_pkg.sv -----
// Shared widths, register indexes and reset values for the rest detector.
package aerd_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned EmaW     = 24;
  localparam int unsigned GainW    = 16;
  localparam int unsigned MarginW  = 23;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned ElapsedW = 8;
  localparam int unsigned IdleW    = 16;
  localparam int unsigned NumAxes  = 3;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 23;

  localparam logic [CfgIdxW-1:0] RegGain    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMargin  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTimeout = 2'd2;

  localparam logic [GainW-1:0]    GainRst    = 16'd6554;
  localparam logic [MarginW-1:0]  MarginRst  = 23'd10486;
  localparam logic [TimeoutW-1:0] TimeoutRst = 16'd5000;

  localparam logic [IdleW-1:0] IdleMax = {IdleW{1'b1}};

endpackage

// ----- rtl/core/aerd_lane.sv -----
// One axis: moving average update and per-axis stillness test.
module aerd_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic signed [aerd_pkg::SampleW-1:0] sample_i,
  input  logic [aerd_pkg::GainW-1:0]          gain_i,
  input  logic [aerd_pkg::MarginW-1:0]        margin_i,
  output logic signed [aerd_pkg::EmaW-1:0]    ema_o,
  output logic                                still_o
);

  logic signed [aerd_pkg::EmaW-1:0] ema_q, ema_d;
  logic                             still_q, still_d;
  logic signed [aerd_pkg::EmaW-1:0] target;
  logic signed [aerd_pkg::EmaW:0]   diff;
  logic signed [41:0]               prod;
  logic signed [aerd_pkg::EmaW:0]   delta;
  logic [aerd_pkg::EmaW:0]          mag;

  always_comb begin
    target  = {sample_i, 8'h00};
    diff    = {target[aerd_pkg::EmaW-1], target} - {ema_q[aerd_pkg::EmaW-1], ema_q};
    prod    = 42'(diff) * $signed({26'd0, gain_i});
    // Arithmetic shift by 16 rounds toward minus infinity.
    delta   = prod[40:16];
    mag     = delta[aerd_pkg::EmaW] ? 25'(-delta) : 25'(delta);
    ema_d   = ema_q + delta[aerd_pkg::EmaW-1:0];
    still_d = mag < {2'b00, margin_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ema_q   <= '0;
      still_q <= 1'b0;
    end else if (en_i) begin
      ema_q   <= ema_d;
      still_q <= still_d;
    end
  end

  assign ema_o   = ema_q;
  assign still_o = still_q;

endmodule

// ----- rtl/core/aerd_merge.sv -----
// Combines the lane stillness flags into the idle counter and display flag.
module aerd_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [aerd_pkg::NumAxes-1:0]      still_i,
  input  logic [aerd_pkg::ElapsedW-1:0]     elapsed_i,
  input  logic [aerd_pkg::TimeoutW-1:0]     timeout_i,
  output logic                              moving_o,
  output logic                              display_on_o
);

  logic [aerd_pkg::IdleW-1:0] idle_q, idle_d;
  logic                       moving_q, moving_d;
  logic                       display_q, display_d;
  logic [aerd_pkg::IdleW:0]   sum;
  logic                       all_still;

  always_comb begin
    all_still = &still_i;
    sum       = {1'b0, idle_q} + {{(aerd_pkg::IdleW + 1 - aerd_pkg::ElapsedW){1'b0}}, elapsed_i};
    if (!all_still) begin
      idle_d = '0;
    end else if (sum[aerd_pkg::IdleW]) begin
      idle_d = aerd_pkg::IdleMax;
    end else begin
      idle_d = sum[aerd_pkg::IdleW-1:0];
    end
    moving_d  = !all_still;
    display_d = idle_d <= timeout_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q    <= '0;
      moving_q  <= 1'b0;
      display_q <= 1'b0;
    end else if (en_i) begin
      idle_q    <= idle_d;
      moving_q  <= moving_d;
      display_q <= display_d;
    end
  end

  assign moving_o     = moving_q;
  assign display_on_o = display_q;

endmodule

// ----- rtl/core/accel_ema_rest_detector_unit.sv -----
// Top level: three-axis moving average rest detector with config registers.
// Registers: the lane stage, then the merge and output stage; a stalled
// output holds its result in the output stage and stalls the lane stage.
// Throughput: one sample per cycle while out_stall_i is low; each lane's
// average loops through one subtract, one 25x17 multiply and one add in logic.
// Reset clears the lane averages, idle counter and valid flags, and loads the
// register defaults (gain 6554, margin 10486, timeout 5000 ms).
module accel_ema_rest_detector_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [aerd_pkg::SampleW-1:0] sample_x_i,
  input  logic signed [aerd_pkg::SampleW-1:0] sample_y_i,
  input  logic signed [aerd_pkg::SampleW-1:0] sample_z_i,
  input  logic [aerd_pkg::ElapsedW-1:0]       elapsed_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [aerd_pkg::EmaW-1:0]    avg_x_o,
  output logic signed [aerd_pkg::EmaW-1:0]    avg_y_o,
  output logic signed [aerd_pkg::EmaW-1:0]    avg_z_o,
  output logic                                moving_o,
  output logic                                display_on_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aerd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [aerd_pkg::CfgDataW-1:0]       cfg_data_i
);

  logic [aerd_pkg::GainW-1:0]    gain_q;
  logic [aerd_pkg::MarginW-1:0]  margin_q;
  logic [aerd_pkg::TimeoutW-1:0] timeout_q;

  logic                          s1_valid_q, s1_valid_d;
  logic [aerd_pkg::ElapsedW-1:0] elapsed_q;
  logic                          out_valid_q, out_valid_d;
  logic signed [aerd_pkg::EmaW-1:0] avg_x_q, avg_y_q, avg_z_q;

  logic                          accept, advance, out_free;
  logic [aerd_pkg::NumAxes-1:0]  still;
  logic signed [aerd_pkg::EmaW-1:0] ema_x, ema_y, ema_z;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= aerd_pkg::GainRst;
      margin_q  <= aerd_pkg::MarginRst;
      timeout_q <= aerd_pkg::TimeoutRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        aerd_pkg::RegGain:    gain_q    <= cfg_data_i[aerd_pkg::GainW-1:0];
        aerd_pkg::RegMargin:  margin_q  <= cfg_data_i[aerd_pkg::MarginW-1:0];
        aerd_pkg::RegTimeout: timeout_q <= cfg_data_i[aerd_pkg::TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  // The lane registers hold the stage-one payload; the output register
  // takes it whenever it is empty or its result is being transferred.
  always_comb begin
    out_free    = !out_valid_q || !out_stall_i;
    advance     = s1_valid_q && out_free;
    in_stall_o  = s1_valid_q && !out_free;
    accept      = in_valid_i && !in_stall_o;
    s1_valid_d  = accept || (s1_valid_q && !out_free);
    out_valid_d = advance || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      elapsed_q <= elapsed_ms_i;
    end
    if (advance) begin
      avg_x_q <= ema_x;
      avg_y_q <= ema_y;
      avg_z_q <= ema_z;
    end
  end

  aerd_lane u_lane_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .sample_i(sample_x_i),
    .gain_i  (gain_q),
    .margin_i(margin_q),
    .ema_o   (ema_x),
    .still_o (still[0])
  );

  aerd_lane u_lane_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .sample_i(sample_y_i),
    .gain_i  (gain_q),
    .margin_i(margin_q),
    .ema_o   (ema_y),
    .still_o (still[1])
  );

  aerd_lane u_lane_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .sample_i(sample_z_i),
    .gain_i  (gain_q),
    .margin_i(margin_q),
    .ema_o   (ema_z),
    .still_o (still[2])
  );

  aerd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .still_i     (still),
    .elapsed_i   (elapsed_q),
    .timeout_i   (timeout_q),
    .moving_o    (moving_o),
    .display_on_o(display_on_o)
  );

  assign out_valid_o = out_valid_q;
  assign avg_x_o     = avg_x_q;
  assign avg_y_o     = avg_y_q;
  assign avg_z_o     = avg_z_q;

endmodule
